FILE: rtl/csp_mix_pkg.sv
// Shared types and constants for the click sample player and mixer.
package csp_mix_pkg;

  // Default number of samples per clip
  localparam int unsigned CLIP_DEPTH_DEF = 8192;

  // Item kinds; code 3 is unused and ignored
  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_TRIGGER = 2'd1,
    FUNC_MIX     = 2'd2
  } func_t;

  // Clip codes; code 3 selects nothing
  localparam logic [1:0] CLIP_BEAT     = 2'd0;
  localparam logic [1:0] CLIP_DOWNBEAT = 2'd1;
  localparam logic [1:0] CLIP_FILL     = 2'd2;
  localparam logic [1:0] CLIP_NONE     = 2'd3;

  // Configuration register indexes
  localparam logic CFG_GAIN_LEFT  = 1'b0;
  localparam logic CFG_GAIN_RIGHT = 1'b1;

  // Unity gain in unsigned Q1.15
  localparam logic [15:0] GAIN_UNITY = 16'h8000;

  // Half an LSB of the Q1.15 product, for round half up
  localparam logic signed [33:0] ROUND_HALF = 34'sd16384;

  // Saturation limits of a Q1.15 sample
  localparam logic signed [18:0] SAT_MAX = 19'sd32767;
  localparam logic signed [18:0] SAT_MIN = -19'sd32768;

endpackage

FILE: rtl/click_sample_player_mixer_core.sv
// Click sample player and mixer: clip store, play control and three-stage stereo mix path.
//
// Holds three mono Q1.15 clips (beat, downbeat, fill) of up to CLIP_DEPTH samples each in
// one clip memory of 3*CLIP_DEPTH words. Load transactions append a sample to a clip (the
// first flag empties it first), trigger transactions start a clip from its first sample
// (downbeat and fill fall back to beat when empty), and each mix transaction carries one
// stereo frame and returns one result; load and trigger transactions return nothing. One
// transaction is taken every clock cycle unless the input stalls. A mix result passes
// through the registered clip memory read, then the two gain multiplies, then the round,
// add and saturate into the output register. Three stage registers hold up to three mix
// results, so input keeps flowing through short output stalls; once all three are full
// the input stalls until the output side takes one. The clip memory needs no clearing
// after reset; gains reset to unity. The user must write gains only while the block is
// idle; the block itself does not enforce this.
module click_sample_player_mixer_core #(
  parameter int unsigned CLIP_DEPTH = csp_mix_pkg::CLIP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [1:0]         in_clip_select,
  input  logic               in_first_sample,
  input  logic signed [15:0] in_clip_sample,
  input  logic signed [15:0] in_mix_left,
  input  logic signed [15:0] in_mix_right,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic               out_click_active,
  output logic               out_clipped
);

  localparam int unsigned LW = $clog2(CLIP_DEPTH + 1);   // length, holds CLIP_DEPTH
  localparam int unsigned PW = $clog2(CLIP_DEPTH);       // position within a clip
  localparam int unsigned AW = $clog2(3 * CLIP_DEPTH);   // clip memory address
  localparam int unsigned MEM_DEPTH = 3 * CLIP_DEPTH;
  localparam logic [LW-1:0] LEN_FULL = LW'(CLIP_DEPTH);
  localparam logic [AW-1:0] BASE_DOWNBEAT = AW'(CLIP_DEPTH);
  localparam logic [AW-1:0] BASE_FILL = AW'(2 * CLIP_DEPTH);

  // Start address of a clip in the memory
  function automatic logic [AW-1:0] clip_base(input logic [1:0] c);
    logic [AW-1:0] b;
    case (c)
      csp_mix_pkg::CLIP_DOWNBEAT: b = BASE_DOWNBEAT;
      csp_mix_pkg::CLIP_FILL:     b = BASE_FILL;
      default:                    b = '0;
    endcase
    return b;
  endfunction

  // Gain registers
  logic [15:0] gain_left_r, gain_right_r;

  // Play state
  logic [LW-1:0] len_r [3];
  logic [LW-1:0] len_nxt [3];
  logic [1:0]    play_clip_r, play_clip_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          playing_r, playing_nxt;

  // Memory access control
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          act_nxt;

  // Pipeline
  logic                s1_v_r, s1_act_r;
  logic signed [15:0]  s1_l_r, s1_r_r;
  logic signed [15:0]  mem_q_r;
  logic                s2_v_r, s2_act_r;
  logic signed [15:0]  s2_l_r, s2_r_r;
  logic signed [31:0]  s2_pl_r, s2_pr_r;
  logic                out_valid_r, out_act_r, out_clip_r;
  logic signed [15:0]  out_l_r, out_r_r;

  logic accept, out_free, s2_free, s1_free, s2_go, s1_go, mix_acc;
  logic [LW-1:0] sel_len, cur_len, base_len, pos_ext;

  logic signed [15:0] mem [MEM_DEPTH];

  // Handshake chain from the output back to the input
  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s2_go    = s2_v_r && out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign s1_go    = s1_v_r && s2_free;
  assign in_ready = s1_free;
  assign cfg_ready = 1'b1;
  assign accept   = in_valid && in_ready;
  assign mix_acc  = accept && (csp_mix_pkg::func_t'(in_func) == csp_mix_pkg::FUNC_MIX);

  // Length of the selected clip and of the playing clip
  assign sel_len = (in_clip_select == csp_mix_pkg::CLIP_BEAT)     ? len_r[0] :
                   (in_clip_select == csp_mix_pkg::CLIP_DOWNBEAT) ? len_r[1] :
                   (in_clip_select == csp_mix_pkg::CLIP_FILL)     ? len_r[2] : '0;
  assign cur_len = (play_clip_r == csp_mix_pkg::CLIP_DOWNBEAT) ? len_r[1] :
                   (play_clip_r == csp_mix_pkg::CLIP_FILL)     ? len_r[2] : len_r[0];
  assign base_len = in_first_sample ? '0 : sel_len;
  assign pos_ext  = LW'(pos_r);

  // Next play state and memory access for the accepted transaction
  always_comb begin
    len_nxt       = len_r;
    play_clip_nxt = play_clip_r;
    pos_nxt       = pos_r;
    playing_nxt   = playing_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = clip_base(in_clip_select) + AW'(base_len);
    rd_addr       = clip_base(play_clip_r) + AW'(pos_r);
    act_nxt       = 1'b0;
    if (accept) begin
      case (csp_mix_pkg::func_t'(in_func))
        csp_mix_pkg::FUNC_LOAD: begin
          if (in_clip_select != csp_mix_pkg::CLIP_NONE) begin
            if (in_first_sample) begin
              len_nxt[in_clip_select] = '0;
            end
            if (base_len < LEN_FULL) begin
              wr_en = 1'b1;
              len_nxt[in_clip_select] = base_len + LW'(1);
            end
          end
        end
        csp_mix_pkg::FUNC_TRIGGER: begin
          if (in_clip_select != csp_mix_pkg::CLIP_NONE) begin
            if (in_clip_select != csp_mix_pkg::CLIP_BEAT && sel_len == '0) begin
              // empty clip falls back to beat
              if (len_r[0] != '0) begin
                play_clip_nxt = csp_mix_pkg::CLIP_BEAT;
                pos_nxt       = '0;
                playing_nxt   = 1'b1;
              end
            end else if (sel_len != '0) begin
              play_clip_nxt = in_clip_select;
              pos_nxt       = '0;
              playing_nxt   = 1'b1;
            end
          end
        end
        csp_mix_pkg::FUNC_MIX: begin
          rd_en = 1'b1;
          if (playing_r && pos_ext < cur_len) begin
            act_nxt     = 1'b1;
            pos_nxt     = PW'(pos_ext + LW'(1));
            playing_nxt = (pos_ext + LW'(1)) < cur_len;
          end else begin
            playing_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration and play state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_left_r  <= csp_mix_pkg::GAIN_UNITY;
      gain_right_r <= csp_mix_pkg::GAIN_UNITY;
      len_r[0]     <= '0;
      len_r[1]     <= '0;
      len_r[2]     <= '0;
      play_clip_r  <= csp_mix_pkg::CLIP_BEAT;
      pos_r        <= '0;
      playing_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == csp_mix_pkg::CFG_GAIN_LEFT) begin
          gain_left_r <= cfg_data;
        end
        if (cfg_index == csp_mix_pkg::CFG_GAIN_RIGHT) begin
          gain_right_r <= cfg_data;
        end
      end
      len_r       <= len_nxt;
      play_clip_r <= play_clip_nxt;
      pos_r       <= pos_nxt;
      playing_r   <= playing_nxt;
    end
  end

  // Clip memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_clip_sample;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= mix_acc;
      end
      if (s2_free) begin
        s2_v_r <= s1_go;
      end
      if (out_free) begin
        out_valid_r <= s2_go;
      end
    end
  end

  // Stage 1: frame held beside the memory read
  always_ff @(posedge clk) begin
    if (mix_acc) begin
      s1_act_r <= act_nxt;
      s1_l_r   <= in_mix_left;
      s1_r_r   <= in_mix_right;
    end
  end

  // Stage 2: sample times gain per channel
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_act_r <= s1_act_r;
      s2_l_r   <= s1_l_r;
      s2_r_r   <= s1_r_r;
      s2_pl_r  <= $signed({{16{mem_q_r[15]}}, mem_q_r}) * $signed({16'd0, gain_left_r});
      s2_pr_r  <= $signed({{16{mem_q_r[15]}}, mem_q_r}) * $signed({16'd0, gain_right_r});
    end
  end

  // Stage 3: add frame, round half up, saturate
  logic signed [33:0] acc_l, acc_r;
  logic signed [18:0] rnd_l, rnd_r;
  logic               hi_l, lo_l, hi_r, lo_r;
  logic signed [15:0] sat_l, sat_r;

  always_comb begin
    acc_l = $signed({{3{s2_l_r[15]}}, s2_l_r, 15'b0}) + 34'(s2_pl_r)
            + csp_mix_pkg::ROUND_HALF;
    acc_r = $signed({{3{s2_r_r[15]}}, s2_r_r, 15'b0}) + 34'(s2_pr_r)
            + csp_mix_pkg::ROUND_HALF;
    rnd_l = acc_l[33:15];
    rnd_r = acc_r[33:15];
    hi_l  = rnd_l > csp_mix_pkg::SAT_MAX;
    lo_l  = rnd_l < csp_mix_pkg::SAT_MIN;
    hi_r  = rnd_r > csp_mix_pkg::SAT_MAX;
    lo_r  = rnd_r < csp_mix_pkg::SAT_MIN;
    sat_l = hi_l ? 16'sh7FFF : (lo_l ? -16'sh8000 : rnd_l[15:0]);
    sat_r = hi_r ? 16'sh7FFF : (lo_r ? -16'sh8000 : rnd_r[15:0]);
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_act_r <= s2_act_r;
      if (s2_act_r) begin
        out_l_r    <= sat_l;
        out_r_r    <= sat_r;
        out_clip_r <= hi_l || lo_l || hi_r || lo_r;
      end else begin
        // no click: frame passes unchanged
        out_l_r    <= s2_l_r;
        out_r_r    <= s2_r_r;
        out_clip_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left         = out_l_r;
  assign out_right        = out_r_r;
  assign out_click_active = out_act_r;
  assign out_clipped      = out_clip_r;

endmodule

FILE: tb/sv/click_sample_player_mixer_core_test.sv
// Self-checking testbench for the click sample player and stereo mixer core.
`timescale 1ns / 100ps

module click_sample_player_mixer_core_test;

  localparam int unsigned DEPTH = csp_mix_pkg::CLIP_DEPTH_DEF;
  // Item kind code that the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One mixed stereo frame as the block reports it
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               active;
    logic               sat;
  } mix_frame_t;

  // Tracks clip and playback state, predicts each mixed frame and checks it
  class click_mix_tracker;
    logic [15:0]        gain_l;
    logic [15:0]        gain_r;
    logic signed [15:0] clip_mem [3*DEPTH];
    int unsigned        clip_len [3];
    logic [1:0]         cur_clip;
    int unsigned        cur_pos;
    bit                 is_playing;
    mix_frame_t         expected_frames [$];
    int unsigned        errors;

    function new();
      gain_l = csp_mix_pkg::GAIN_UNITY;
      gain_r = csp_mix_pkg::GAIN_UNITY;
      foreach (clip_len[i]) clip_len[i] = 0;
      cur_clip = csp_mix_pkg::CLIP_BEAT;
      cur_pos = 0;
      is_playing = 0;
      errors = 0;
    endfunction

    function void set_gain(logic idx, logic [15:0] value);
      if (idx == csp_mix_pkg::CFG_GAIN_LEFT) gain_l = value;
      else gain_r = value;
    endfunction

    function int unsigned waiting();
      return expected_frames.size();
    endfunction

    // frame*32768 + smp*gain, round half up, saturate to 16 bits
    function logic signed [15:0] mix_one(logic signed [15:0] frame,
                                         logic signed [15:0] smp,
                                         logic [15:0] gain, inout bit sat);
      longint acc;
      longint res;
      acc = longint'(frame) * 32768 + longint'(smp) * longint'(gain) + 16384;
      res = acc >>> 15;
      if (res > 32767) begin
        sat = 1;
        return 16'sh7fff;
      end
      if (res < -32768) begin
        sat = 1;
        return 16'sh8000;
      end
      return 16'(res);
    endfunction

    // Update state for an accepted input transaction
    function void absorb_item(logic [1:0] func, logic [1:0] sel, logic first,
                              logic signed [15:0] smp, logic signed [15:0] fl,
                              logic signed [15:0] fr);
      logic [1:0] c;
      mix_frame_t f;
      bit         sat;
      case (func)
        csp_mix_pkg::FUNC_LOAD: begin
          if (sel == csp_mix_pkg::CLIP_NONE) return;
          if (first) clip_len[sel] = 0;
          if (clip_len[sel] < DEPTH) begin
            clip_mem[sel*DEPTH + clip_len[sel]] = smp;
            clip_len[sel]++;
          end
        end
        csp_mix_pkg::FUNC_TRIGGER: begin
          c = sel;
          if (c == csp_mix_pkg::CLIP_NONE) return;
          // empty downbeat or fill falls back to beat
          if (c != csp_mix_pkg::CLIP_BEAT && clip_len[c] == 0) c = csp_mix_pkg::CLIP_BEAT;
          if (clip_len[c] == 0) return;
          cur_clip = c;
          cur_pos = 0;
          is_playing = 1;
        end
        csp_mix_pkg::FUNC_MIX: begin
          sat = 0;
          f.left = fl;
          f.right = fr;
          f.active = 0;
          // clip emptied or shortened under the play position stops play
          if (is_playing && cur_pos >= clip_len[cur_clip]) is_playing = 0;
          if (is_playing) begin
            f.left = mix_one(fl, clip_mem[cur_clip*DEPTH + cur_pos], gain_l, sat);
            f.right = mix_one(fr, clip_mem[cur_clip*DEPTH + cur_pos], gain_r, sat);
            f.active = 1;
            cur_pos++;
            if (cur_pos >= clip_len[cur_clip]) is_playing = 0;
          end
          f.sat = sat;
          expected_frames.push_back(f);
        end
        default: ;
      endcase
    endfunction

    function void report(string what, mix_frame_t want, mix_frame_t got);
      errors++;
      if (errors <= 10)
        $display("%0t: %s: expected L=%0d R=%0d act=%0b clip=%0b, %s",
                 $time, what, want.left, want.right, want.active, want.sat,
                 $sformatf("got L=%0d R=%0d act=%0b clip=%0b",
                           got.left, got.right, got.active, got.sat));
    endfunction

    // Compare an accepted result transaction with the oldest expected frame
    function void check_frame(mix_frame_t got);
      mix_frame_t want;
      want = '0;
      if (expected_frames.size() == 0) begin
        report("result with nothing expected", want, got);
        return;
      end
      want = expected_frames.pop_front();
      if (want.left !== got.left || want.right !== got.right ||
          want.active !== got.active || want.sat !== got.sat)
        report("frame mismatch", want, got);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic [1:0]         in_clip_select;
  logic               in_first_sample;
  logic signed [15:0] in_clip_sample;
  logic signed [15:0] in_mix_left;
  logic signed [15:0] in_mix_right;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic               out_click_active;
  logic               out_clipped;

  click_mix_tracker tracker;
  int unsigned      items_sent;
  int unsigned      in_quiet;
  int unsigned      out_quiet;
  bit               hold_request;

  click_sample_player_mixer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_clip_select   (in_clip_select),
    .in_first_sample  (in_first_sample),
    .in_clip_sample   (in_clip_sample),
    .in_mix_left      (in_mix_left),
    .in_mix_right     (in_mix_right),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left         (out_left),
    .out_right        (out_right),
    .out_click_active (out_click_active),
    .out_clipped      (out_clipped)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Idle cycles before a transaction, with occasional stretches of none
  function automatic int unsigned draw_gap(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic signed [15:0] rand_word();
    return 16'($urandom);
  endfunction

  // Random sample that favors the extremes now and then
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return rand_word();
    endcase
  endfunction

  // Offer one input transaction; returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] func, logic [1:0] sel, logic first,
                           logic signed [15:0] smp, logic signed [15:0] fl,
                           logic signed [15:0] fr);
    int unsigned gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = func;
    in_clip_select = sel;
    in_first_sample = first;
    in_clip_sample = smp;
    in_mix_left = fl;
    in_mix_right = fr;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.absorb_item(func, sel, first, smp, fl, fr);
    if (func != FUNC_UNUSED &&
        !(func != csp_mix_pkg::FUNC_MIX && sel == csp_mix_pkg::CLIP_NONE)) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(logic [1:0] sel, logic first, logic signed [15:0] smp);
    send_item(csp_mix_pkg::FUNC_LOAD, sel, first, smp, rand_word(), rand_word());
  endtask

  task automatic send_trigger(logic [1:0] sel);
    send_item(csp_mix_pkg::FUNC_TRIGGER, sel, 1'($urandom), rand_word(), rand_word(),
              rand_word());
  endtask

  task automatic send_mix(logic signed [15:0] fl, logic signed [15:0] fr);
    send_item(csp_mix_pkg::FUNC_MIX, 2'($urandom), 1'($urandom), rand_word(), fl, fr);
  endtask

  // Drain all results, let loads settle, then write both gains
  task automatic set_gains(logic [15:0] gl, logic [15:0] gr);
    in_valid = 1'b0;
    while (tracker.waiting() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    for (int i = 0; i < 2; i++) begin
      cfg_index = (i == 0) ? csp_mix_pkg::CFG_GAIN_LEFT : csp_mix_pkg::CFG_GAIN_RIGHT;
      cfg_data = (i == 0) ? gl : gr;
      cfg_valid = 1'b1;
      do @(posedge clk); while (!cfg_ready);
      tracker.set_gain(cfg_index, cfg_data);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // Random sequences, mostly well formed, until the budget is used up
  task automatic run_random(int unsigned budget);
    int unsigned start;
    int unsigned n;
    logic [1:0]  sel;
    start = items_sent;
    while (items_sent - start < budget) begin
      sel = ($urandom_range(0, 15) == 0) ? csp_mix_pkg::CLIP_NONE
                                         : 2'($urandom_range(0, 2));
      n = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int i = 0; i < n; i++)
            send_load(sel, (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                      rand_sample());
        end
        3, 4, 5: begin
          send_trigger(sel);
          for (int i = 0; i < n + 6; i++) send_mix(rand_sample(), rand_sample());
        end
        6, 7: begin
          for (int i = 0; i < n / 2 + 1; i++) send_mix(rand_sample(), rand_sample());
        end
        8: begin
          // reload the playing clip while it plays
          send_trigger(sel);
          for (int i = 0; i < n; i++) begin
            send_mix(rand_sample(), rand_sample());
            if ($urandom_range(0, 2) == 0)
              send_load(sel, $urandom_range(0, 3) == 0, rand_sample());
          end
        end
        default: begin
          for (int i = 0; i < n / 6 + 1; i++)
            send_item(2'($urandom), 2'($urandom), 1'($urandom), rand_word(), rand_word(),
                      rand_word());
        end
      endcase
    end
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 0;
      end
      gap = draw_gap(out_quiet);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_frame({out_left, out_right, out_click_active, out_clipped});
  end

  // Run limit
  initial begin
    #8000000;
    $display("click_sample_player_mixer_core_test: done, errors");
    $finish;
  end

  // Main stimulus
  initial begin
    logic [15:0] gl;
    logic [15:0] gr;
    tracker = new();
    items_sent = 0;
    in_quiet = 0;
    out_quiet = 0;
    hold_request = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = csp_mix_pkg::CFG_GAIN_LEFT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_func = csp_mix_pkg::FUNC_LOAD;
    in_clip_select = csp_mix_pkg::CLIP_BEAT;
    in_first_sample = 1'b0;
    in_clip_sample = '0;
    in_mix_left = '0;
    in_mix_right = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: no clip, empty triggers, ignored codes
    send_mix(16'sh7fff, 16'sh8000);
    send_trigger(csp_mix_pkg::CLIP_BEAT);
    send_trigger(csp_mix_pkg::CLIP_DOWNBEAT);
    send_mix(16'sh8000, 16'sh7fff);
    send_load(csp_mix_pkg::CLIP_NONE, 1'b1, 16'sh1234);
    send_trigger(csp_mix_pkg::CLIP_NONE);
    send_item(FUNC_UNUSED, csp_mix_pkg::CLIP_BEAT, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    // Beat clip with extreme samples; fill falls back to beat
    send_load(csp_mix_pkg::CLIP_BEAT, 1'b1, 16'sh7fff);
    send_load(csp_mix_pkg::CLIP_BEAT, 1'b0, 16'sh8000);
    send_load(csp_mix_pkg::CLIP_BEAT, 1'b0, 16'sh0000);
    send_trigger(csp_mix_pkg::CLIP_FILL);
    send_mix(16'sh7fff, 16'sh7fff);
    send_mix(16'sh8000, 16'sh8000);
    send_mix(16'sh4000, 16'shc000);
    send_mix(16'sh0001, 16'shffff);
    // Downbeat shortened under the play position stops play
    send_load(csp_mix_pkg::CLIP_DOWNBEAT, 1'b1, 16'shffff);
    send_load(csp_mix_pkg::CLIP_DOWNBEAT, 1'b0, 16'sh0001);
    send_trigger(csp_mix_pkg::CLIP_DOWNBEAT);
    send_mix(16'sh0000, 16'sh0000);
    send_load(csp_mix_pkg::CLIP_DOWNBEAT, 1'b1, 16'sh0005);
    send_mix(16'sh0100, 16'sh0100);
    send_trigger(csp_mix_pkg::CLIP_DOWNBEAT);
    send_mix(16'sh0000, 16'sh0000);

    // Random phases over several gain settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin gl = csp_mix_pkg::GAIN_UNITY; gr = csp_mix_pkg::GAIN_UNITY; end
        1: begin gl = 16'h0000; gr = 16'hffff; end
        2: begin gl = 16'hffff; gr = 16'h0000; end
        default: begin gl = 16'($urandom); gr = 16'($urandom); end
      endcase
      set_gains(gl, gr);
      if (p == 2) hold_request = 1;
      run_random(340);
    end

    // Wait for all frames, then let the pipeline settle
    in_valid = 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.waiting() == 0)
      $display("click_sample_player_mixer_core_test: done, clean");
    else
      $display("click_sample_player_mixer_core_test: done, errors");
    $finish;
  end

endmodule
